// ----- rtl/escape_time_fractal_point_core_defines.svh -----
// assertion macros for the escape time fractal point core
// no dependencies; included by the top level only
`ifndef ESCAPE_TIME_FRACTAL_POINT_CORE_DEFINES_SVH
`define ESCAPE_TIME_FRACTAL_POINT_CORE_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define ETFP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define ETFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/etfp_pkg.sv -----
// shared types, codes and table function for the escape time fractal point core
// no dependencies
package etfp_pkg;

    typedef logic signed [127:0] t_wide;

    // data handed from one multiplier cell to the next
    typedef struct packed {
        logic        vld;
        logic        neg;
        logic [63:0] am;
        logic [63:0] bm;
        logic [127:0] acc;
    } t_mul_link;

    // one complex multiply step of an iteration
    typedef struct packed {
        logic [1:0] psel;
        logic [1:0] rsel;
        logic       dst;
        logic       last;
    } t_step;

    localparam logic [2:0] CFG_MODE  = 3'd0;
    localparam logic [2:0] CFG_JULIA = 3'd1;
    localparam logic [2:0] CFG_JR    = 3'd2;
    localparam logic [2:0] CFG_JI    = 3'd3;
    localparam logic [2:0] CFG_LIMIT = 3'd4;

    localparam logic [2:0] MODE_POW3    = 3'd0;
    localparam logic [2:0] MODE_POW4    = 3'd1;
    localparam logic [2:0] MODE_POW5    = 3'd2;
    localparam logic [2:0] MODE_POW6    = 3'd3;
    localparam logic [2:0] MODE_POW8    = 3'd4;
    localparam logic [2:0] MODE_POW10   = 3'd5;
    localparam logic [2:0] MODE_TRICORN = 3'd6;
    localparam logic [2:0] MODE_BUFFALO = 3'd7;

    localparam logic [1:0] SRC_Z  = 2'd0;
    localparam logic [1:0] SRC_W1 = 2'd1;
    localparam logic [1:0] SRC_W2 = 2'd2;
    localparam logic [1:0] SRC_F  = 2'd3;

    localparam logic DST_W1 = 1'b0;
    localparam logic DST_W2 = 1'b1;

    function automatic t_step mk_step(input logic [1:0] p, input logic [1:0] r,
                                      input logic d, input logic l);
        t_step s;
        s.psel = p;
        s.rsel = r;
        s.dst  = d;
        s.last = l;
        return s;
    endfunction

    // multiply program per formula; step 0 of every power squares z
    function automatic t_step step_info(input logic [2:0] mode, input logic [1:0] step);
        t_step s;
        s = mk_step(SRC_Z, SRC_Z, DST_W1, 1'b0);
        case (mode)
            MODE_POW3: begin
                if (step != 2'd0) s = mk_step(SRC_W1, SRC_Z, DST_W1, 1'b1);
            end
            MODE_POW4: begin
                if (step != 2'd0) s = mk_step(SRC_W1, SRC_W1, DST_W1, 1'b1);
            end
            MODE_POW5: begin
                if (step == 2'd1) s = mk_step(SRC_W1, SRC_W1, DST_W2, 1'b0);
                else if (step != 2'd0) s = mk_step(SRC_W2, SRC_Z, DST_W1, 1'b1);
            end
            MODE_POW6: begin
                if (step == 2'd1) s = mk_step(SRC_W1, SRC_Z, DST_W2, 1'b0);
                else if (step != 2'd0) s = mk_step(SRC_W2, SRC_W2, DST_W1, 1'b1);
            end
            MODE_POW8: begin
                if (step == 2'd1) s = mk_step(SRC_W1, SRC_W1, DST_W2, 1'b0);
                else if (step != 2'd0) s = mk_step(SRC_W2, SRC_W2, DST_W1, 1'b1);
            end
            MODE_POW10: begin
                if (step == 2'd1) s = mk_step(SRC_W1, SRC_W1, DST_W2, 1'b0);
                else if (step == 2'd2) s = mk_step(SRC_W2, SRC_Z, DST_W1, 1'b0);
                else if (step == 2'd3) s = mk_step(SRC_W1, SRC_W1, DST_W1, 1'b1);
            end
            default: begin
                s = mk_step(SRC_F, SRC_F, DST_W1, 1'b1);
            end
        endcase
        return s;
    endfunction

    // log2(1 + j/2^lb) in Q16 by repeated squaring; evaluated at elaboration
    function automatic logic [16:0] log_entry(input int unsigned j, input int unsigned lb);
        logic [63:0] x;
        logic [20:0] r;
        r = '0;
        if (j >= (32'd1 << lb)) return 17'h10000;
        x = (64'd1 << 30) + ((64'(j) << 30) >> lb);
        for (int k = 0; k < 20; k++) begin
            x = (x * x) >> 30;
            if (x >= (64'd1 << 31)) begin
                x = x >> 1;
                r[19-k] = 1'b1;
            end
        end
        return 17'((r + 21'd8) >> 4);
    endfunction

endpackage

// ----- rtl/etfp_mul_cell.sv -----
// one cell of the multiplier chain: a 32x32 partial product added into the
// running sum handed on by the previous cell; uses etfp_pkg
module etfp_mul_cell #(
    parameter int A_HI  = 0,
    parameter int B_HI  = 0,
    parameter int SHIFT = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  etfp_pkg::t_mul_link  i_link,
    output etfp_pkg::t_mul_link  o_link
);
    etfp_pkg::t_mul_link r_link;
    logic                r_vld;
    logic [63:0]         r_prod;
    logic [31:0]         a_dig;
    logic [31:0]         b_dig;

    assign a_dig = (A_HI != 0) ? i_link.am[63:32] : i_link.am[31:0];
    assign b_dig = (B_HI != 0) ? i_link.bm[63:32] : i_link.bm[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_link.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_link <= i_link;
        r_prod <= 64'(a_dig) * 64'(b_dig);
    end

    always_comb begin
        o_link     = r_link;
        o_link.vld = r_vld;
        o_link.acc = r_link.acc + ({64'd0, r_prod} << SHIFT);
    end
endmodule

// ----- rtl/etfp_mul_chain.sv -----
// exact signed 64x64 multiplier built as a chain of four partial product cells
// one product accepted every cycle; uses etfp_pkg, etfp_mul_cell
module etfp_mul_chain (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  logic signed [63:0]  i_a,
    input  logic signed [63:0]  i_b,
    output logic                o_vld,
    output etfp_pkg::t_wide     o_prod
);
    etfp_pkg::t_mul_link link [5];
    logic                r_in_vld;
    logic                r_neg;
    logic [63:0]         r_am;
    logic [63:0]         r_bm;
    logic                r_mag_vld;
    logic                r_mag_neg;
    logic [127:0]        r_mag;
    logic                r_out_vld;
    etfp_pkg::t_wide     r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_mag_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= i_vld;
            r_mag_vld <= link[4].vld;
            r_out_vld <= r_mag_vld;
        end
    end

    // magnitudes and product sign
    always_ff @(posedge i_clk) begin
        r_am      <= i_a[63] ? 64'(-i_a) : i_a;
        r_bm      <= i_b[63] ? 64'(-i_b) : i_b;
        r_neg     <= i_a[63] ^ i_b[63];
        r_mag     <= link[4].acc;
        r_mag_neg <= link[4].neg;
        r_out     <= r_mag_neg ? -$signed(r_mag) : $signed(r_mag);
    end

    always_comb begin
        link[0].vld = r_in_vld;
        link[0].neg = r_neg;
        link[0].am  = r_am;
        link[0].bm  = r_bm;
        link[0].acc = '0;
    end

    for (genvar k = 0; k < 4; k++) begin : g_cell
        etfp_mul_cell #(
            .A_HI (k % 2),
            .B_HI (k / 2),
            .SHIFT(32 * ((k % 2) + (k / 2)))
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_link (link[k]),
            .o_link (link[k+1])
        );
    end

    assign o_vld  = r_out_vld;
    assign o_prod = r_out;
endmodule

// ----- rtl/escape_time_fractal_point_core.sv -----
// escape time fractal point core: top level with sequencer, log2 unit and
// configuration registers; uses etfp_pkg, etfp_mul_chain and the defines header
//
// One point is taken when start is high and busy is low; busy then stays high
// until the single result has been shown. The result sits on o_escaped,
// o_iteration_count and o_smooth_value for exactly one cycle with o_valid high;
// the receiver cannot stall it and must take it in that cycle. Every product
// goes through one shared multiplier, a chain of four 32x32 partial product
// cells. A complex multiply step issues four products back to back; an
// iteration runs 1 step (tricorn, buffalo), 2 (z^3, z^4), 3 (z^5, z^6, z^8)
// or 4 (z^10) steps, then a right shift one bit at a time when the value
// overflows, and two squares for |z|^2. An escape adds two passes of the log2
// unit (normalize 16 or 1 bits a cycle, table lookup, one interpolation
// product). Points are handled one at a time. Configuration is to be written
// by the user while busy is low, which the block itself does not enforce; no
// clearing pass is needed after reset.
`include "escape_time_fractal_point_core_defines.svh"
module escape_time_fractal_point_core #(
    parameter int COORD_WIDTH       = 32,
    parameter int LOG_TABLE_ENTRIES = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_point_real,
    input  logic signed [COORD_WIDTH-1:0] i_point_imag,
    input  logic                          i_cfg_wr_en,
    input  logic [2:0]                    i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    output logic                          o_valid,
    output logic                          o_escaped,
    output logic [15:0]                   o_iteration_count,
    output logic signed [31:0]            o_smooth_value
);
    localparam int LB = $clog2(LOG_TABLE_ENTRIES);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_COMB  = 4'd3;
    localparam logic [3:0] S_ABS   = 4'd4;
    localparam logic [3:0] S_NORM  = 4'd5;
    localparam logic [3:0] S_SQ    = 4'd6;
    localparam logic [3:0] S_SUM   = 4'd7;
    localparam logic [3:0] S_LNORM = 4'd8;
    localparam logic [3:0] S_LTAB  = 4'd9;
    localparam logic [3:0] S_LDIFF = 4'd10;
    localparam logic [3:0] S_LMUL  = 4'd11;
    localparam logic [3:0] S_LRES  = 4'd12;

    // configuration registers
    logic [2:0]         r_mode;
    logic               r_julia;
    logic signed [31:0] r_jr;
    logic signed [31:0] r_ji;
    logic [15:0]        r_limit;

    // control
    logic [3:0]  r_state;
    logic [15:0] r_iter;
    logic [1:0]  r_step;
    logic [2:0]  r_issue;
    logic [1:0]  r_recv;
    logic        r_lphase;
    logic        r_o_valid;

    // datapath
    logic signed [63:0] r_zr, r_zi, r_fr, r_fi;
    logic signed [63:0] r_w1r, r_w1i, r_w2r, r_w2i;
    logic signed [31:0] r_kr, r_ki;
    etfp_pkg::t_wide    r_part [4];
    etfp_pkg::t_wide    r_re, r_im;
    logic [127:0]       r_ur, r_ui;
    logic [6:0]         r_sh;
    logic [127:0]       r_lv;
    logic [6:0]         r_lp;
    logic [16:0]        r_ta, r_tb, r_d;
    logic [31:0]        r_rem;
    logic [23:0]        r_log;
    logic               r_o_escaped;
    logic [15:0]        r_o_count;
    logic signed [31:0] r_o_smooth;

    // multiplier chain
    logic               mul_in_vld;
    logic signed [63:0] mul_a, mul_b;
    logic               mul_out_vld;
    etfp_pkg::t_wide    mul_prod;

    etfp_mul_chain u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (mul_in_vld),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_vld  (mul_out_vld),
        .o_prod (mul_prod)
    );

    // log2 table, one entry more than the index range for interpolation
    logic [16:0] log_tab [LOG_TABLE_ENTRIES + 1];
    for (genvar g = 0; g <= LOG_TABLE_ENTRIES; g++) begin : g_tab
        assign log_tab[g] = etfp_pkg::log_entry(g, LB);
    end

    // input coordinates, sign extended and clamped to 32 bits
    logic signed [63:0] pr_ext, pi_ext;
    logic signed [31:0] pr_c, pi_c;
    always_comb begin
        pr_ext = 64'(i_point_real);
        pi_ext = 64'(i_point_imag);
        if (pr_ext > 64'sd2147483647) pr_c = 32'sh7FFFFFFF;
        else if (pr_ext < -64'sd2147483648) pr_c = 32'sh80000000;
        else pr_c = pr_ext[31:0];
        if (pi_ext > 64'sd2147483647) pi_c = 32'sh7FFFFFFF;
        else if (pi_ext < -64'sd2147483648) pi_c = 32'sh80000000;
        else pi_c = pi_ext[31:0];
    end

    // current step and its operands
    etfp_pkg::t_step    cur;
    logic signed [63:0] op_p, op_q, op_r, op_s;
    always_comb begin
        cur = etfp_pkg::step_info(r_mode, r_step);
        case (cur.psel)
            etfp_pkg::SRC_Z:  begin op_p = r_zr;  op_q = r_zi;  end
            etfp_pkg::SRC_W1: begin op_p = r_w1r; op_q = r_w1i; end
            etfp_pkg::SRC_W2: begin op_p = r_w2r; op_q = r_w2i; end
            default:          begin op_p = r_fr;  op_q = r_fi;  end
        endcase
        case (cur.rsel)
            etfp_pkg::SRC_Z:  begin op_r = r_zr;  op_s = r_zi;  end
            etfp_pkg::SRC_W1: begin op_r = r_w1r; op_s = r_w1i; end
            etfp_pkg::SRC_W2: begin op_r = r_w2r; op_s = r_w2i; end
            default:          begin op_r = r_fr;  op_s = r_fi;  end
        endcase
    end

    // product issue: p*r, q*s, p*s, q*r for a step; squares; interpolation
    always_comb begin
        mul_in_vld = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        case (r_state)
            S_MUL: begin
                mul_in_vld = (r_issue < 3'd4);
                case (r_issue[1:0])
                    2'd0:    begin mul_a = op_p; mul_b = op_r; end
                    2'd1:    begin mul_a = op_q; mul_b = op_s; end
                    2'd2:    begin mul_a = op_p; mul_b = op_s; end
                    default: begin mul_a = op_q; mul_b = op_r; end
                endcase
            end
            S_SQ: begin
                mul_in_vld = (r_issue < 3'd2);
                mul_a = r_issue[0] ? $signed(r_ui[63:0]) : $signed(r_ur[63:0]);
                mul_b = mul_a;
            end
            S_LMUL: begin
                mul_in_vld = (r_issue == 3'd0);
                mul_a = $signed({47'd0, r_d});
                mul_b = $signed({32'd0, r_rem});
            end
            default: begin
                mul_in_vld = 1'b0;
            end
        endcase
    end

    // combining terms
    logic signed [63:0] comb_re, comb_im;
    etfp_pkg::t_wide    kr_term, ki_term, fin_re, fin_im;
    logic [127:0]       sq_sum;
    logic               esc;
    always_comb begin
        comb_re = r_part[0][91:28] - r_part[1][91:28];
        comb_im = r_part[2][91:28] + r_part[3][91:28];
        kr_term = {{68{r_kr[31]}}, r_kr, 28'd0};
        ki_term = {{68{r_ki[31]}}, r_ki, 28'd0};
        fin_re  = (r_part[0] - r_part[1] + kr_term) >>> 28;
        fin_im  = (r_part[2] + r_part[3] + ki_term) >>> 28;
        sq_sum  = r_part[0] + r_part[1];
        // escape when the shift was needed or |z|^2 is above 256 (2^64 raw)
        esc = (r_sh != 7'd0) || (sq_sum[127:65] != '0) ||
              (sq_sum[64] && (sq_sum[63:0] != 64'd0));
    end

    // log2 lookup pieces
    logic [31:0] lfrac;
    logic [LB:0] tab_lo, tab_hi;
    always_comb begin
        lfrac  = r_lv[126:95];
        tab_lo = {1'b0, lfrac[31 -: LB]};
        tab_hi = tab_lo + (LB+1)'(1);
    end

    // results of a log2 pass
    logic signed [8:0]  sh_term;
    logic signed [31:0] l_val;
    logic signed [24:0] nu;
    logic signed [34:0] sm;
    logic [16:0]        iter_p1;
    logic signed [31:0] sm_sat;
    logic signed [31:0] limit_sat;
    always_comb begin
        sh_term = $signed({1'b0, r_sh, 1'b0}) - 9'sd56;
        l_val   = $signed({8'd0, r_log}) + $signed({{7{sh_term[8]}}, sh_term, 16'd0});
        nu      = $signed({1'b0, r_log}) - 25'sd1114112;
        iter_p1 = 17'(r_iter) + 17'd1;
        sm      = $signed({2'b00, iter_p1, 16'd0}) - 35'(nu);
        if (sm > 35'sd2147483647) sm_sat = 32'sh7FFFFFFF;
        else if (sm < -35'sd2147483648) sm_sat = 32'sh80000000;
        else sm_sat = sm[31:0];
        limit_sat = r_limit[15] ? 32'sh7FFFFFFF : $signed({1'b0, r_limit[14:0], 16'd0});
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= etfp_pkg::MODE_POW3;
            r_julia <= 1'b0;
            r_jr    <= '0;
            r_ji    <= '0;
            r_limit <= 16'd256;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                etfp_pkg::CFG_MODE:  r_mode  <= i_cfg_data[2:0];
                etfp_pkg::CFG_JULIA: r_julia <= i_cfg_data[0];
                etfp_pkg::CFG_JR:    r_jr    <= $signed(i_cfg_data);
                etfp_pkg::CFG_JI:    r_ji    <= $signed(i_cfg_data);
                etfp_pkg::CFG_LIMIT: r_limit <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_iter    <= '0;
            r_step    <= '0;
            r_issue   <= '0;
            r_recv    <= '0;
            r_lphase  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= 1'b0;
            if (mul_in_vld) r_issue <= r_issue + 3'd1;
            if (mul_out_vld) r_recv <= r_recv + 2'd1;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_iter  <= '0;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_iter == r_limit) begin
                        r_o_valid <= 1'b1;
                        r_state   <= S_IDLE;
                    end else begin
                        r_step  <= '0;
                        r_issue <= '0;
                        r_recv  <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (mul_out_vld && (r_recv == 2'd3)) r_state <= S_COMB;
                end
                S_COMB: begin
                    r_issue <= '0;
                    r_recv  <= '0;
                    if (cur.last) begin
                        r_state <= S_ABS;
                    end else begin
                        r_step  <= r_step + 2'd1;
                        r_state <= S_MUL;
                    end
                end
                S_ABS: begin
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    if ((r_ur[127:62] | r_ui[127:62]) == '0) begin
                        r_issue <= '0;
                        r_recv  <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (mul_out_vld && (r_recv == 2'd1)) r_state <= S_SUM;
                end
                S_SUM: begin
                    if (esc) begin
                        r_lphase <= 1'b0;
                        r_state  <= S_LNORM;
                    end else begin
                        r_iter  <= r_iter + 16'd1;
                        r_state <= S_CHECK;
                    end
                end
                S_LNORM: begin
                    if (r_lv == '0) r_state <= S_LRES;
                    else if (r_lv[127]) r_state <= S_LTAB;
                end
                S_LTAB: begin
                    r_state <= S_LDIFF;
                end
                S_LDIFF: begin
                    r_issue <= '0;
                    r_recv  <= '0;
                    r_state <= S_LMUL;
                end
                S_LMUL: begin
                    if (mul_out_vld) r_state <= S_LRES;
                end
                S_LRES: begin
                    if (!r_lphase) begin
                        r_lphase <= 1'b1;
                        r_state  <= S_LNORM;
                    end else begin
                        r_o_valid <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        // formula-specific view of z for tricorn and buffalo
        if (r_mode == etfp_pkg::MODE_BUFFALO) begin
            r_fr <= r_zr[63] ? -r_zr : r_zr;
            r_fi <= r_zi[63] ? -r_zi : r_zi;
        end else begin
            r_fr <= r_zr;
            r_fi <= -r_zi;
        end
        if (mul_out_vld) r_part[r_recv] <= mul_prod;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (r_julia) begin
                        r_zr <= 64'(pr_c);
                        r_zi <= 64'(pi_c);
                        r_kr <= r_jr;
                        r_ki <= r_ji;
                    end else begin
                        r_zr <= '0;
                        r_zi <= '0;
                        r_kr <= pr_c;
                        r_ki <= pi_c;
                    end
                end
            end
            S_CHECK: begin
                if (r_iter == r_limit) begin
                    r_o_escaped <= 1'b0;
                    r_o_count   <= r_limit;
                    r_o_smooth  <= limit_sat;
                end
            end
            S_COMB: begin
                if (cur.last) begin
                    r_re <= fin_re;
                    r_im <= fin_im;
                end else if (cur.dst == etfp_pkg::DST_W2) begin
                    r_w2r <= comb_re;
                    r_w2i <= comb_im;
                end else begin
                    r_w1r <= comb_re;
                    r_w1i <= comb_im;
                end
            end
            S_ABS: begin
                r_ur <= r_re[127] ? 128'(-r_re) : 128'(r_re);
                r_ui <= r_im[127] ? 128'(-r_im) : 128'(r_im);
                r_sh <= '0;
            end
            S_NORM: begin
                // scale both parts down until they fit below 2^62
                if ((r_ur[127:62] | r_ui[127:62]) != '0) begin
                    r_ur <= r_ur >> 1;
                    r_ui <= r_ui >> 1;
                    r_sh <= r_sh + 7'd1;
                end
            end
            S_SUM: begin
                if (esc) begin
                    r_lv <= sq_sum;
                    r_lp <= 7'd127;
                end else begin
                    r_zr <= r_re[63:0];
                    r_zi <= r_im[63:0];
                end
            end
            S_LNORM: begin
                if (r_lv == '0) begin
                    r_log <= '0;
                end else if (r_lv[127:112] == 16'd0) begin
                    r_lv <= r_lv << 16;
                    r_lp <= r_lp - 7'd16;
                end else if (!r_lv[127]) begin
                    r_lv <= r_lv << 1;
                    r_lp <= r_lp - 7'd1;
                end
            end
            S_LTAB: begin
                r_ta  <= log_tab[tab_lo];
                r_tb  <= log_tab[tab_hi];
                r_rem <= 32'(lfrac << LB);
            end
            S_LDIFF: begin
                r_d <= (r_tb >= r_ta) ? (r_tb - r_ta) : 17'd0;
            end
            S_LMUL: begin
                if (mul_out_vld) begin
                    r_log <= {1'b0, r_lp, 16'd0} + 24'(r_ta) + 24'(mul_prod[48:32]);
                end
            end
            S_LRES: begin
                if (!r_lphase) begin
                    // second pass takes log2 of log2|z|^2, clipped at zero
                    r_lv <= (l_val > 32'sd0) ? 128'(unsigned'(l_val)) : 128'd0;
                    r_lp <= 7'd127;
                end else begin
                    r_o_escaped <= 1'b1;
                    r_o_count   <= iter_p1[15:0];
                    r_o_smooth  <= sm_sat;
                end
            end
            default: ;
        endcase
    end

    assign busy              = (r_state != S_IDLE);
    assign o_valid           = r_o_valid;
    assign o_escaped         = r_o_escaped;
    assign o_iteration_count = r_o_count;
    assign o_smooth_value    = r_o_smooth;

    // accepted request starts work at once
    `ETFP_ASSERT_NEXT(a_start_busy, start && !busy, busy, "request accepted but core not busy")
    // a result closes a busy period
    `ETFP_ASSERT_SAME(a_valid_after_busy, o_valid, $past(busy) && !busy,
                      "result shown outside a busy period")
    // one strobe per request
    `ETFP_ASSERT_NEXT(a_single_strobe, o_valid, !o_valid, "result strobe longer than one cycle")
    // an escape always reports at least one iteration
    `ETFP_ASSERT_SAME(a_escape_count, o_valid && o_escaped, o_iteration_count != 16'd0,
                      "escape reported with zero iterations")
endmodule

// ----- test/escape_time_fractal_point_core_tb.sv -----
// self-checking testbench for escape_time_fractal_point_core
// depends on etfp_pkg and the core rtl; predicts each point in a scoreboard class
`timescale 1ns / 1ps

module escape_time_fractal_point_core_tb;

    localparam int      CLK_PERIOD   = 10;
    localparam int      STALL_LIMIT  = 300000;
    localparam int      LOG_N        = 256;
    localparam longint  Q16_ONE      = 65536;

    // expected outcome of one point
    typedef struct {
        logic        escaped;
        logic [15:0] count;
        logic [31:0] smooth;
    } t_point_result;

    // golden predictor plus queue of outstanding results
    class fractal_scoreboard;
        logic [2:0]     mode;
        logic           julia_on;
        longint         julia_re;
        longint         julia_im;
        int unsigned    iter_limit;
        longint unsigned log_tbl[LOG_N+1];
        t_point_result  pending_results[$];
        int             errors;
        int             points_sent;
        int             results_seen;
        int             escapes_seen;
        int             mode_hits[8];

        function new();
            longint unsigned x;
            logic [19:0]     r;
            mode = etfp_pkg::MODE_POW3;
            julia_on = 1'b0;
            julia_re = 0;
            julia_im = 0;
            iter_limit = 256;
            errors = 0;
            points_sent = 0;
            results_seen = 0;
            escapes_seen = 0;
            foreach (mode_hits[m]) mode_hits[m] = 0;
            // log2(1 + j/N) by repeated squaring, msb first
            for (int j = 0; j < LOG_N; j++) begin
                x = (64'd1 << 30) + ((64'(j) << 30) / LOG_N);
                r = '0;
                for (int k = 0; k < 20; k++) begin
                    x = (x * x) >> 30;
                    if (x >= (64'd1 << 31)) begin
                        x = x >> 1;
                        r[19-k] = 1'b1;
                    end
                end
                log_tbl[j] = (64'(r) + 8) >> 4;
            end
            log_tbl[LOG_N] = 65536;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                etfp_pkg::CFG_MODE:  mode = data[2:0];
                etfp_pkg::CFG_JULIA: julia_on = data[0];
                etfp_pkg::CFG_JR:    julia_re = longint'(signed'(data));
                etfp_pkg::CFG_JI:    julia_im = longint'(signed'(data));
                etfp_pkg::CFG_LIMIT: iter_limit = data[15:0];
                default: ;
            endcase
        endfunction

        // q.28 product, floored, wrapped to 64 bits
        function longint mul_fx(longint a, longint b);
            etfp_pkg::t_wide p;
            p = (etfp_pkg::t_wide'(a) * etfp_pkg::t_wide'(b)) >>> 28;
            return p[63:0];
        endfunction

        // log2 in q16 of an unsigned 128-bit value with table interpolation
        function longint log2_fx(logic [127:0] v);
            int              p;
            logic [31:0]     f;
            longint unsigned idx, rem, a, b, d;
            if (v == 0) return 0;
            p = 127;
            while (!v[127]) begin
                v = v << 1;
                p--;
            end
            f = v[126:95];
            idx = f[31:24];
            rem = {f[23:0], 8'h00};
            a = log_tbl[idx];
            b = log_tbl[idx+1];
            d = (b >= a) ? b - a : 0;
            return longint'(p) * Q16_ONE + longint'(a + ((d * rem) >> 32));
        endfunction

        function t_point_result escape_result(longint pr, longint pi);
            t_point_result   res;
            longint          zr, zi, kr, ki, x, y, p, q, r, s;
            longint          a2, b2, a3, b3, a4, b4, a5, b5, lg, nu, sm;
            etfp_pkg::t_wide re, im;
            logic [127:0]    ur, ui, sum;
            int              sh;
            if (julia_on) begin
                zr = pr; zi = pi; kr = julia_re; ki = julia_im;
            end else begin
                zr = 0; zi = 0; kr = pr; ki = pi;
            end
            for (int unsigned i = 0; i < iter_limit; i++) begin
                x = zr;
                y = zi;
                a2 = mul_fx(x, x) - mul_fx(y, y);
                b2 = 2 * mul_fx(x, y);
                a3 = mul_fx(a2, x) - mul_fx(b2, y);
                b3 = mul_fx(a2, y) + mul_fx(b2, x);
                a4 = mul_fx(a2, a2) - mul_fx(b2, b2);
                b4 = 2 * mul_fx(a2, b2);
                a5 = mul_fx(a4, x) - mul_fx(b4, y);
                b5 = mul_fx(a4, y) + mul_fx(b4, x);
                case (mode)
                    etfp_pkg::MODE_POW3:    begin p = a2; q = b2; r = x;  s = y;  end
                    etfp_pkg::MODE_POW4:    begin p = a2; q = b2; r = a2; s = b2; end
                    etfp_pkg::MODE_POW5:    begin p = a4; q = b4; r = x;  s = y;  end
                    etfp_pkg::MODE_POW6:    begin p = a3; q = b3; r = a3; s = b3; end
                    etfp_pkg::MODE_POW8:    begin p = a4; q = b4; r = a4; s = b4; end
                    etfp_pkg::MODE_POW10:   begin p = a5; q = b5; r = a5; s = b5; end
                    etfp_pkg::MODE_TRICORN: begin p = x;  q = -y; r = x;  s = -y; end
                    default: begin
                        p = (x < 0) ? -x : x;
                        q = (y < 0) ? -y : y;
                        r = p;
                        s = q;
                    end
                endcase
                re = etfp_pkg::t_wide'(p) * etfp_pkg::t_wide'(r)
                   - etfp_pkg::t_wide'(q) * etfp_pkg::t_wide'(s)
                   + (etfp_pkg::t_wide'(kr) <<< 28);
                im = etfp_pkg::t_wide'(p) * etfp_pkg::t_wide'(s)
                   + etfp_pkg::t_wide'(q) * etfp_pkg::t_wide'(r)
                   + (etfp_pkg::t_wide'(ki) <<< 28);
                re = re >>> 28;
                im = im >>> 28;
                ur = re[127] ? ~re + 1 : re;
                ui = im[127] ? ~im + 1 : im;
                sh = 0;
                // scale down until both parts fit below 2^62
                while (ur >= (128'd1 << 62) || ui >= (128'd1 << 62)) begin
                    ur = ur >> 1;
                    ui = ui >> 1;
                    sh++;
                end
                sum = ur * ur + ui * ui;
                if (sh > 0 || sum > (128'd1 << 64)) begin
                    lg = log2_fx(sum) + longint'(2 * sh - 56) * Q16_ONE;
                    nu = log2_fx((lg > 0) ? 128'(lg) : 128'd0) - 17 * Q16_ONE;
                    sm = longint'(i + 1) * Q16_ONE - nu;
                    if (sm > 64'sh7FFF_FFFF) sm = 64'sh7FFF_FFFF;
                    if (sm < -64'sh8000_0000) sm = -64'sh8000_0000;
                    res.escaped = 1'b1;
                    res.count = 16'(i + 1);
                    res.smooth = sm[31:0];
                    return res;
                end
                zr = re[63:0];
                zi = im[63:0];
            end
            // never escaped: limit in q16.16, saturated
            sm = longint'(iter_limit) * Q16_ONE;
            if (sm > 64'sh7FFF_FFFF) sm = 64'sh7FFF_FFFF;
            res.escaped = 1'b0;
            res.count = 16'(iter_limit);
            res.smooth = sm[31:0];
            return res;
        endfunction

        function void note_point(logic [31:0] pr, logic [31:0] pi);
            pending_results.push_back(escape_result(longint'(signed'(pr)),
                                                    longint'(signed'(pi))));
            points_sent++;
            mode_hits[mode]++;
        endfunction

        function void check_result(logic esc, logic [15:0] cnt, logic [31:0] sm);
            t_point_result exp_res;
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result esc=%0b count=%0d smooth=%h",
                         $time, esc, cnt, sm);
                errors++;
                return;
            end
            exp_res = pending_results.pop_front();
            if (exp_res.escaped) escapes_seen++;
            if (esc !== exp_res.escaped) begin
                $display("%0t: escaped expected %0b actual %0b", $time, exp_res.escaped, esc);
                errors++;
            end
            if (cnt !== exp_res.count) begin
                $display("%0t: iteration_count expected %0d actual %0d",
                         $time, exp_res.count, cnt);
                errors++;
            end
            if (sm !== exp_res.smooth) begin
                $display("%0t: smooth_value expected %h actual %h",
                         $time, exp_res.smooth, sm);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] i_point_real = '0;
    logic [31:0] i_point_imag = '0;
    logic        i_cfg_wr_en = 1'b0;
    logic [2:0]  i_cfg_index = etfp_pkg::CFG_MODE;
    logic [31:0] i_cfg_data = '0;
    logic        o_valid;
    logic        o_escaped;
    logic [15:0] o_iteration_count;
    logic [31:0] o_smooth_value;

    fractal_scoreboard sb = new();
    int idle_pct = 0;
    int stall_cycles = 0;

    escape_time_fractal_point_core u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_point_real      (i_point_real),
        .i_point_imag      (i_point_imag),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_valid           (o_valid),
        .o_escaped         (o_escaped),
        .o_iteration_count (o_iteration_count),
        .o_smooth_value    (o_smooth_value)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // result monitor; outputs are sampled before the edge updates them
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            sb.check_result(o_escaped, o_iteration_count, o_smooth_value);
        end
    end

    // watchdog: too long without any request or result means a hang
    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (start && !busy)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: watchdog expired with %0d results outstanding",
                         $time, sb.pending_results.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // register write while the core is idle; one cycle of enable
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // present one point and hold it until the core takes the request
    task automatic send_point(input logic [31:0] pr, input logic [31:0] pi);
        i_point_real <= pr;
        i_point_imag <= pi;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note_point(pr, pi);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // drop start and let every outstanding result come back
    task automatic drain;
        start <= 1'b0;
        while (sb.pending_results.size() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // mostly points near the interesting region, some anywhere, some extremes
    function automatic logic [31:0] rand_coord();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70) return 32'($signed($urandom_range(0, 1342177280)) - 671088640);
        if (pick < 90) return $urandom();
        case ($urandom_range(4))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return 32'h0000_0001;
        endcase
    endfunction

    task automatic random_setting(input int unsigned max_limit);
        write_reg(etfp_pkg::CFG_MODE, $urandom());
        write_reg(etfp_pkg::CFG_JULIA, $urandom());
        write_reg(etfp_pkg::CFG_JR, 32'($signed($urandom_range(0, 805306368)) - 402653184));
        write_reg(etfp_pkg::CFG_JI, 32'($signed($urandom_range(0, 805306368)) - 402653184));
        write_reg(etfp_pkg::CFG_LIMIT, $urandom_range(1, max_limit));
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: z^3, mandelbrot, limit 256; origin never escapes
        send_point(32'h0000_0000, 32'h0000_0000);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000);
        send_point(32'h1000_0000, 32'hF000_0000);
        drain();

        // zero limit via data bits above the register width
        write_reg(etfp_pkg::CFG_LIMIT, 32'h0001_0000);
        send_point(32'h0400_0000, 32'h0200_0000);
        drain();

        // widest limit with early escape, buffalo via masked upper bits
        write_reg(etfp_pkg::CFG_MODE, 32'hFFFF_FFFF);
        write_reg(etfp_pkg::CFG_LIMIT, 32'h0000_FFFF);
        send_point(32'h8000_0000, 32'h7FFF_FFFF);
        drain();

        // writes to indexes past the register list must be ignored
        write_reg(3'd5, 32'hFFFF_FFFF);
        write_reg(3'd6, 32'h0000_0001);
        write_reg(3'd7, 32'h1234_5678);

        // each formula once at a point near the boundary
        write_reg(etfp_pkg::CFG_LIMIT, 20);
        for (int m = 0; m < 8; m++) begin
            write_reg(etfp_pkg::CFG_MODE, m);
            send_point(32'hF800_0000, 32'h0A00_0000);
            drain();
        end

        // julia mode with extreme constants
        write_reg(etfp_pkg::CFG_JULIA, 32'hFFFF_FFFF);
        write_reg(etfp_pkg::CFG_JR, 32'h8000_0000);
        write_reg(etfp_pkg::CFG_JI, 32'h7FFF_FFFF);
        send_point(32'h0000_0000, 32'h0000_0000);
        drain();
        write_reg(etfp_pkg::CFG_MODE, etfp_pkg::MODE_POW4);
        send_point(32'h0100_0000, 32'hFF00_0000);
        drain();

        // random phases: sender busy, then quiet, then back to back
        for (int ph = 0; ph < 15; ph++) begin
            idle_pct = (ph < 5) ? 34 : (ph < 10) ? 81 : 0;
            random_setting((ph % 4 == 3) ? 64 : 24);
            repeat (38) send_point(rand_coord(), rand_coord());
            drain();
        end

        // leftover expectations count as failures
        if (sb.pending_results.size() > 0) begin
            $display("%0t: %0d results never arrived", $time, sb.pending_results.size());
            sb.errors += sb.pending_results.size();
        end
        $display("covered %0d points, %0d results, %0d escaped, across all 8 formulas",
                 sb.points_sent, sb.results_seen, sb.escapes_seen);
        $display("formula use: %0d %0d %0d %0d %0d %0d %0d %0d, errors %0d",
                 sb.mode_hits[0], sb.mode_hits[1], sb.mode_hits[2], sb.mode_hits[3],
                 sb.mode_hits[4], sb.mode_hits[5], sb.mode_hits[6], sb.mode_hits[7],
                 sb.errors);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
